// File: sv/mcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcce_pkg;

  // Fixed field widths of the item and result ports
  localparam int unsigned DIM_IN_W = 16;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned COST_W   = 63;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Character codes
  localparam logic [SYM_W-1:0] ASCII_A      = 8'h41;
  localparam logic [SYM_W-1:0] ASCII_Z      = 8'h5A;
  localparam logic [SYM_W-1:0] ASCII_RPAREN = 8'h29;

  // Item modes
  localparam logic MODE_DEFINE = 1'b0;
  localparam logic MODE_EXPR   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_POP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_ACC,
    ST_END
  } st_e;

endpackage

`default_nettype wire

// File: sv/matrix_chain_cost_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        request in in_valid_i / in_ready_o  mode_i symbol_i rows_i cols_i last_i
// out       result out out_valid_o / out_ready_i total_cost_o error_o
//
// One request is worked at a time. A ')' takes a stack read, three passes through the
// shared DIM_BITS x DIM_BITS multiplier, term saturation and a saturating accumulate.
// Reset marks every letter undefined and empties the stack; memories are not cleared.
// A finished result sits in the output register while the next request is taken; only
// a last character whose result finds that register still full waits for out_ready_i.

module matrix_chain_cost_evaluator #(
  parameter int unsigned STACK_DEPTH   = 64,
  parameter int unsigned DIM_BITS      = 16,
  parameter int unsigned TABLE_ENTRIES = 26
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [mcce_pkg::SYM_W-1:0]   symbol_i,
  input  logic [mcce_pkg::DIM_IN_W-1:0] rows_i,
  input  logic [mcce_pkg::DIM_IN_W-1:0] cols_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mcce_pkg::COST_W-1:0]  total_cost_o,
  output logic                         error_o
);

  import mcce_pkg::*;

  localparam int unsigned TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SAW    = $clog2(STACK_DEPTH);
  localparam int unsigned TOP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PROD_W = 2 * DIM_BITS;
  localparam int unsigned TERM_W = (3 * DIM_BITS > COST_W + 1) ? 3 * DIM_BITS : COST_W + 1;

  st_e state_q, state_d;

  // Expression state
  logic [TOP_W-1:0]    top_q, top_d;
  logic                failed_q, failed_d;
  logic [COST_W-1:0]   acc_q, acc_d;
  logic [DIM_BITS-1:0] tos_rows_q, tos_rows_d;
  logic [DIM_BITS-1:0] tos_cols_q, tos_cols_d;

  // Per-request working registers
  logic                last_q, last_d;
  logic                in_table_q, in_table_d;
  logic [DIM_BITS-1:0] a_rows_q, a_rows_d;
  logic [PROD_W-1:0]   mul_q;
  logic [DIM_BITS-1:0] p1_hi_q, p1_hi_d;
  logic [PROD_W-1:0]   lo_q, lo_d;
  logic [COST_W-1:0]   term_q, term_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [COST_W-1:0]   cost_out_q, cost_out_d;
  logic                err_out_q, err_out_d;

  // Multiplier operands
  logic                mul_en;
  logic [DIM_BITS-1:0] mul_a, mul_b;

  // Request decode
  logic                accept;
  logic [SYM_W-1:0]    sym_idx;
  logic                sym_in_table;
  logic                sym_is_letter;
  logic [DIM_BITS-1:0] in_rows, in_cols;

  // Memory ports
  logic                tbl_wr_en, tbl_rd_en, tbl_known;
  logic [DIM_BITS-1:0] tbl_rows, tbl_cols;
  logic                stk_wr_en, stk_rd_en;
  logic [SAW-1:0]      stk_wr_addr, stk_rd_addr;
  logic [PROD_W-1:0]   stk_rd_data;
  logic [DIM_BITS-1:0] stk_a_rows, stk_a_cols;

  // Arithmetic helpers
  logic [TERM_W-1:0]   term_full;
  logic [COST_W:0]     acc_sum;
  logic [TOP_W-1:0]    top_m1, top_m2;
  logic                out_free;

  assign accept        = in_valid_i && in_ready_o;
  assign sym_idx       = symbol_i - ASCII_A;
  assign sym_in_table  = sym_idx < SYM_W'(TABLE_ENTRIES);
  assign sym_is_letter = symbol_i inside {[ASCII_A:ASCII_Z]};
  assign in_rows       = DIM_BITS'(rows_i);
  assign in_cols       = DIM_BITS'(cols_i);

  assign top_m1      = top_q - TOP_W'(1);
  assign top_m2      = top_q - TOP_W'(2);
  assign stk_a_rows  = stk_rd_data[PROD_W-1:DIM_BITS];
  assign stk_a_cols  = stk_rd_data[DIM_BITS-1:0];
  assign out_free    = !out_valid_q || out_ready_i;

  // Term = (p1_hi * bc) << DIM_BITS + p1_lo * bc, clipped to the cost range
  assign term_full = TERM_W'({mul_q, {DIM_BITS{1'b0}}}) + TERM_W'(lo_q);
  assign acc_sum   = {1'b0, acc_q} + {1'b0, term_q};

  mcce_dim_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .DIM_BITS     (DIM_BITS),
    .TBL_AW       (TBL_AW)
  ) u_dim_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_wr_en),
    .wr_idx_i  (sym_idx[TBL_AW-1:0]),
    .wr_rows_i (in_rows),
    .wr_cols_i (in_cols),
    .rd_en_i   (tbl_rd_en),
    .rd_idx_i  (sym_idx[TBL_AW-1:0]),
    .rd_rows_o (tbl_rows),
    .rd_cols_o (tbl_cols),
    .rd_known_o(tbl_known)
  );

  // Entries below the top of stack; the top itself lives in tos_rows_q/tos_cols_q
  mcce_stack_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(PROD_W),
    .AW   (SAW)
  ) u_stack_ram (
    .clk_i    (clk_i),
    .wr_en_i  (stk_wr_en),
    .wr_addr_i(stk_wr_addr),
    .wr_data_i({tos_rows_q, tos_cols_q}),
    .rd_en_i  (stk_rd_en),
    .rd_addr_i(stk_rd_addr),
    .rd_data_o(stk_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      failed_q    <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      top_q       <= top_d;
      failed_q    <= failed_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_rows_q <= tos_rows_d;
    tos_cols_q <= tos_cols_d;
    last_q     <= last_d;
    in_table_q <= in_table_d;
    a_rows_q   <= a_rows_d;
    p1_hi_q    <= p1_hi_d;
    lo_q       <= lo_d;
    term_q     <= term_d;
    cost_out_q <= cost_out_d;
    err_out_q  <= err_out_d;
    if (mul_en) begin
      mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    failed_d    = failed_q;
    acc_d       = acc_q;
    tos_rows_d  = tos_rows_q;
    tos_cols_d  = tos_cols_q;
    last_d      = last_q;
    in_table_d  = in_table_q;
    a_rows_d    = a_rows_q;
    p1_hi_d     = p1_hi_q;
    lo_d        = lo_q;
    term_d      = term_q;
    out_valid_d = out_valid_q;
    cost_out_d  = cost_out_q;
    err_out_d   = err_out_q;

    in_ready_o  = 1'b0;
    tbl_wr_en   = 1'b0;
    tbl_rd_en   = 1'b0;
    stk_wr_en   = 1'b0;
    stk_wr_addr = top_m1[SAW-1:0];
    stk_rd_en   = 1'b0;
    stk_rd_addr = top_m2[SAW-1:0];
    mul_en      = 1'b0;
    mul_a       = stk_a_rows;
    mul_b       = stk_a_cols;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          last_d     = last_i;
          in_table_d = sym_in_table;
          if (mode_i == MODE_DEFINE) begin
            // Store the dimensions; last carries no meaning here
            tbl_wr_en = sym_in_table;
          end else if (failed_q) begin
            state_d = ST_END;
          end else if (sym_is_letter) begin
            tbl_rd_en = sym_in_table;
            state_d   = ST_LOOKUP;
          end else if (symbol_i == ASCII_RPAREN) begin
            if (top_q < TOP_W'(2)) begin
              failed_d = 1'b1;
              state_d  = ST_END;
            end else begin
              stk_rd_en = 1'b1;
              state_d   = ST_POP;
            end
          end else begin
            state_d = ST_END;
          end
        end
      end

      ST_LOOKUP: begin
        if (!(in_table_q && tbl_known)) begin
          failed_d = 1'b1;
        end else if (top_q == TOP_W'(STACK_DEPTH)) begin
          failed_d = 1'b1;
        end else begin
          // Spill the old top into memory, then hold the new one in registers
          stk_wr_en  = (top_q != '0);
          tos_rows_d = tbl_rows;
          tos_cols_d = tbl_cols;
          top_d      = top_q + TOP_W'(1);
        end
        state_d = ST_END;
      end

      ST_POP: begin
        // A comes from memory, B is the held top
        a_rows_d = stk_a_rows;
        if (stk_a_cols != tos_rows_q) begin
          failed_d = 1'b1;
          state_d  = ST_END;
        end else begin
          mul_en  = 1'b1;
          state_d = ST_MUL_LO;
        end
      end

      ST_MUL_LO: begin
        mul_en  = 1'b1;
        mul_a   = mul_q[DIM_BITS-1:0];
        mul_b   = tos_cols_q;
        p1_hi_d = mul_q[PROD_W-1:DIM_BITS];
        state_d = ST_MUL_HI;
      end

      ST_MUL_HI: begin
        mul_en  = 1'b1;
        mul_a   = p1_hi_q;
        mul_b   = tos_cols_q;
        lo_d    = mul_q;
        state_d = ST_SUM;
      end

      ST_SUM: begin
        if (term_full[TERM_W-1:COST_W] != '0) begin
          term_d = COST_MAX;
        end else begin
          term_d = term_full[COST_W-1:0];
        end
        state_d = ST_ACC;
      end

      ST_ACC: begin
        acc_d      = acc_sum[COST_W] ? COST_MAX : acc_sum[COST_W-1:0];
        tos_rows_d = a_rows_q;
        top_d      = top_m1;
        state_d    = ST_END;
      end

      ST_END: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          // Report and clear the expression
          out_valid_d = 1'b1;
          if (failed_q || top_q != TOP_W'(1)) begin
            err_out_d  = 1'b1;
            cost_out_d = '0;
          end else begin
            err_out_d  = 1'b0;
            cost_out_d = acc_q;
          end
          top_d    = '0;
          failed_d = 1'b0;
          acc_d    = '0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign total_cost_o = cost_out_q;
  assign error_o      = err_out_q;

endmodule

`default_nettype wire

// File: sv/mcce_dim_table.sv
`timescale 1ns / 1ps
`default_nettype none

module mcce_dim_table #(
  parameter int unsigned TABLE_ENTRIES = 26,
  parameter int unsigned DIM_BITS      = 16,
  parameter int unsigned TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [TBL_AW-1:0]   wr_idx_i,
  input  logic [DIM_BITS-1:0] wr_rows_i,
  input  logic [DIM_BITS-1:0] wr_cols_i,
  input  logic                rd_en_i,
  input  logic [TBL_AW-1:0]   rd_idx_i,
  output logic [DIM_BITS-1:0] rd_rows_o,
  output logic [DIM_BITS-1:0] rd_cols_o,
  output logic                rd_known_o
);

  logic [2*DIM_BITS-1:0]  mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] known_q;
  logic [2*DIM_BITS-1:0]  rd_data_q;
  logic                   rd_known_q;

  // Dimension storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= {wr_rows_i, wr_cols_i};
    end
    if (rd_en_i) begin
      rd_data_q  <= mem_q[rd_idx_i];
      rd_known_q <= known_q[rd_idx_i];
    end
  end

  // Mark entries defined; reset forgets every letter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= '0;
    end else if (wr_en_i) begin
      known_q[wr_idx_i] <= 1'b1;
    end
  end

  assign rd_rows_o  = rd_data_q[2*DIM_BITS-1:DIM_BITS];
  assign rd_cols_o  = rd_data_q[DIM_BITS-1:0];
  assign rd_known_o = rd_known_q;

endmodule

`default_nettype wire

// File: sv/mcce_stack_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mcce_stack_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: tb/matrix_chain_cost_evaluator_test.sv
`timescale 1ns / 1ps

module matrix_chain_cost_evaluator_test;
  import mcce_pkg::*;

  // Match the default parameters of the block
  localparam int CHAIN_DEPTH  = 64;
  localparam int TABLE_SIZE   = 26;
  localparam int RANDOM_CHARS = 640;
  // ')' steps of 65535^3 each in the closing chain
  localparam int CALM_TERMS   = 20;
  localparam int SQUEEZE_AT   = 400;
  localparam int SQUEEZE_LEN  = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int STALL_LIMIT  = 5000;

  // Characters the block ignores, and letters the package does not name
  localparam logic [SYM_W-1:0] CH_LPAREN    = 8'h28;
  localparam logic [SYM_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [SYM_W-1:0] CH_AT        = 8'h40;
  localparam logic [SYM_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [SYM_W-1:0] SYM_ALL_ONES = 8'hFF;
  localparam logic [SYM_W-1:0] CH_B         = ASCII_A + 8'd1;
  localparam logic [SYM_W-1:0] CH_C         = ASCII_A + 8'd2;

  localparam logic [DIM_IN_W-1:0] DIM_0   = '0;
  localparam logic [DIM_IN_W-1:0] DIM_1   = 16'd1;
  localparam logic [DIM_IN_W-1:0] DIM_MAX = '1;
  localparam logic [COST_W-1:0]   NO_COST = '0;

  localparam logic MORE      = 1'b0;
  localparam logic LAST      = 1'b1;
  localparam logic PREDICT   = 1'b0;
  localparam logic TYPED     = 1'b1;
  localparam logic RES_OK    = 1'b0;
  localparam logic RES_ERROR = 1'b1;

  // One request, plus an expected result where it is typed into the table
  typedef struct packed {
    logic                mode;
    logic [SYM_W-1:0]    sym;
    logic [DIM_IN_W-1:0] rows;
    logic [DIM_IN_W-1:0] cols;
    logic                is_last;
    logic                typed;
    logic [COST_W-1:0]   cost;
    logic                err;
  } req_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              err;
  } chain_result_t;

  localparam int NUM_DIRECTED = 23;
  localparam req_t DIRECTED [NUM_DIRECTED] = '{
    // mode       symbol        rows     cols     last  check    cost     error
    // letter before any define
    '{MODE_EXPR,   ASCII_A,      DIM_0,   DIM_0,   LAST, TYPED,   NO_COST, RES_ERROR},
    // defines of symbols outside the table, then one with last set
    '{MODE_DEFINE, ASCII_RPAREN, DIM_MAX, DIM_MAX, MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_DEFINE, CH_AT,        DIM_1,   DIM_1,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_DEFINE, CH_LBRACKET,  DIM_1,   DIM_1,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_DEFINE, SYM_ALL_ONES, DIM_1,   DIM_1,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_DEFINE, ASCII_A,      DIM_0,   DIM_MAX, LAST, PREDICT, NO_COST, RES_OK},
    // redefine A, then fill Z and B
    '{MODE_DEFINE, ASCII_A,      DIM_MAX, DIM_MAX, MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_DEFINE, ASCII_Z,      DIM_MAX, DIM_MAX, MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_DEFINE, CH_B,         DIM_MAX, DIM_1,   MORE, PREDICT, NO_COST, RES_OK},
    // (AZ): the largest single term
    '{MODE_EXPR,   CH_LPAREN,    DIM_MAX, DIM_MAX, MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_EXPR,   ASCII_A,      DIM_0,   DIM_0,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_EXPR,   ASCII_Z,      DIM_MAX, DIM_0,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_EXPR,   ASCII_RPAREN, DIM_0,   DIM_MAX, LAST, PREDICT, NO_COST, RES_OK},
    // ')' on an empty stack
    '{MODE_EXPR,   ASCII_RPAREN, DIM_0,   DIM_0,   LAST, TYPED,   NO_COST, RES_ERROR},
    // B then A do not conform; Z after the error is dropped
    '{MODE_EXPR,   CH_B,         DIM_0,   DIM_0,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_EXPR,   ASCII_A,      DIM_0,   DIM_0,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_EXPR,   ASCII_RPAREN, DIM_0,   DIM_0,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_EXPR,   ASCII_Z,      DIM_0,   DIM_0,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_EXPR,   CH_SPACE,     DIM_0,   DIM_0,   LAST, TYPED,   NO_COST, RES_ERROR},
    // two operands left at the end
    '{MODE_EXPR,   ASCII_A,      DIM_0,   DIM_0,   MORE, PREDICT, NO_COST, RES_OK},
    '{MODE_EXPR,   ASCII_Z,      DIM_0,   DIM_0,   LAST, TYPED,   NO_COST, RES_ERROR},
    // nothing on the stack at the end
    '{MODE_EXPR,   SYM_ALL_ONES, DIM_0,   DIM_0,   LAST, TYPED,   NO_COST, RES_ERROR},
    // a lone operand costs nothing
    '{MODE_EXPR,   ASCII_A,      DIM_0,   DIM_0,   LAST, TYPED,   NO_COST, RES_OK}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                mode_i;
  logic [SYM_W-1:0]    symbol_i;
  logic [DIM_IN_W-1:0] rows_i;
  logic [DIM_IN_W-1:0] cols_i;
  logic                last_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [COST_W-1:0]   total_cost_o;
  logic                error_o;

  matrix_chain_cost_evaluator dut (.*);

  // Requests still to be offered, and results still to come back
  req_t              char_stream [$];
  chain_result_t     pending_costs [$];
  logic [SYM_W-1:0]  scratch_chars [$];

  int n_total;
  int n_accepted;
  int calm_from = 32'h7fffffff;
  int n_fail;
  int n_results;
  int n_err_results;

  // Shadow copy of the dimension table and the operand stack
  logic [DIM_IN_W-1:0] tbl_rows  [TABLE_SIZE];
  logic [DIM_IN_W-1:0] tbl_cols  [TABLE_SIZE];
  bit                  tbl_known [TABLE_SIZE];
  logic [DIM_IN_W-1:0] stk_rows  [CHAIN_DEPTH];
  logic [DIM_IN_W-1:0] stk_cols  [CHAIN_DEPTH];
  int                  chain_top;
  logic [COST_W-1:0]   chain_cost = '0;
  bit                  chain_failed;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one accepted request to the shadow state; return 1 when it ends an expression
  function automatic bit eval_chain_char(input req_t r, output logic [COST_W-1:0] cost,
                                         output logic err);
    int id;
    logic [DIM_IN_W-1:0] ar, ac, br, bc;
    logic [63:0] term;
    cost = '0;
    err  = 1'b0;
    id   = int'(r.sym) - int'(ASCII_A);
    if (r.mode == MODE_DEFINE) begin
      if (r.sym >= ASCII_A && id < TABLE_SIZE) begin
        tbl_rows[id]  = r.rows;
        tbl_cols[id]  = r.cols;
        tbl_known[id] = 1'b1;
      end
      return 1'b0;
    end
    if (!chain_failed) begin
      if (r.sym >= ASCII_A && r.sym <= ASCII_Z) begin
        if (id >= TABLE_SIZE || !tbl_known[id] || chain_top >= CHAIN_DEPTH) begin
          chain_failed = 1'b1;
        end else begin
          stk_rows[chain_top] = tbl_rows[id];
          stk_cols[chain_top] = tbl_cols[id];
          chain_top++;
        end
      end else if (r.sym == ASCII_RPAREN) begin
        if (chain_top < 2) begin
          chain_failed = 1'b1;
        end else begin
          br = stk_rows[chain_top-1];
          bc = stk_cols[chain_top-1];
          ar = stk_rows[chain_top-2];
          ac = stk_cols[chain_top-2];
          chain_top -= 2;
          if (ac != br) begin
            chain_failed = 1'b1;
          end else begin
            // 16-bit factors keep the product within 48 bits; only the sum can saturate
            term = 64'(ar) * 64'(ac) * 64'(bc);
            if (term > 64'(COST_MAX - chain_cost)) chain_cost = COST_MAX;
            else chain_cost = chain_cost + term[COST_W-1:0];
            stk_rows[chain_top] = ar;
            stk_cols[chain_top] = bc;
            chain_top++;
          end
        end
      end
    end
    if (!r.is_last) return 1'b0;
    err  = chain_failed || chain_top != 1;
    cost = err ? NO_COST : chain_cost;
    chain_top    = 0;
    chain_cost   = '0;
    chain_failed = 1'b0;
    return 1'b1;
  endfunction

  function automatic void queue_req(logic mode, logic [SYM_W-1:0] sym,
                                    logic [DIM_IN_W-1:0] rows, logic [DIM_IN_W-1:0] cols,
                                    logic is_last);
    req_t r;
    r = '0;
    r.mode    = mode;
    r.sym     = sym;
    r.rows    = rows;
    r.cols    = cols;
    r.is_last = is_last;
    char_stream.push_back(r);
  endfunction

  // Any byte the expression parser skips, '(' most often
  function automatic logic [SYM_W-1:0] noise_char();
    logic [SYM_W-1:0] c;
    if ($urandom_range(0, 2) == 0) return CH_LPAREN;
    do c = 8'($urandom); while ((c >= ASCII_A && c <= ASCII_Z) || c == ASCII_RPAREN);
    return c;
  endfunction

  // Emit a random full parenthesization of leaves lo..hi
  function automatic void build_tree(int lo, int hi, int base);
    int split;
    if (lo == hi) begin
      scratch_chars.push_back(ASCII_A + 8'((base + lo) % TABLE_SIZE));
      return;
    end
    split = $urandom_range(lo, hi - 1);
    scratch_chars.push_back(CH_LPAREN);
    build_tree(lo, split, base);
    build_tree(split + 1, hi, base);
    scratch_chars.push_back(ASCII_RPAREN);
  endfunction

  // Gaps stop in the final stretch and pause for every third block of 150 requests
  function automatic bit idle_allowed(int n);
    return n < calm_from && (n / 150) % 3 != 2;
  endfunction

  // Request side: offer the stream, predict each accepted request
  initial begin : req_driver
    req_t              cur;
    chain_result_t     res;
    logic [COST_W-1:0] p_cost;
    logic              p_err;
    int                gap;
    in_valid_i <= 1'b0;
    mode_i     <= MODE_DEFINE;
    symbol_i   <= '0;
    rows_i     <= '0;
    cols_i     <= '0;
    last_i     <= 1'b0;
    gap = 0;
    cur = '0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (in_valid_i && in_ready_o) begin
        if (eval_chain_char(cur, p_cost, p_err)) begin
          res.cost = cur.typed ? cur.cost : p_cost;
          res.err  = cur.typed ? cur.err : p_err;
          pending_costs.push_back(res);
        end
        n_accepted++;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the request until it is taken
      end else if (gap > 0) begin
        gap--;
        in_valid_i <= 1'b0;
      end else if (char_stream.size() != 0 && idle_allowed(n_accepted) &&
                   $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(0, 9);
        in_valid_i <= 1'b0;
      end else if (char_stream.size() != 0) begin
        cur = char_stream.pop_front();
        in_valid_i <= 1'b1;
        mode_i     <= cur.mode;
        symbol_i   <= cur.sym;
        rows_i     <= cur.rows;
        cols_i     <= cur.cols;
        last_i     <= cur.is_last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: stall at random, once for a long stretch, and check every result
  initial begin : result_sink
    chain_result_t want;
    int            hold;
    bit            squeezed;
    out_ready_i <= 1'b0;
    hold     = 0;
    squeezed = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_costs.size() == 0) begin
          if (n_fail < 10)
            $display("unexpected result: cost %0d error %0b", total_cost_o, error_o);
          n_fail++;
        end else begin
          want = pending_costs.pop_front();
          n_results++;
          if (want.err) n_err_results++;
          if (total_cost_o !== want.cost || error_o !== want.err) begin
            if (n_fail < 10)
              $display("mismatch on result %0d: cost exp %0d got %0d, error exp %0b got %0b",
                       n_results, want.cost, total_cost_o, want.err, error_o);
            n_fail++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!squeezed && n_accepted >= SQUEEZE_AT) begin
        // refuse results long enough for the block to back up into its input
        squeezed = 1'b1;
        hold = SQUEEZE_LEN - 1;
        out_ready_i <= 1'b0;
      end else if (idle_allowed(n_accepted) && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Abort when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("no request or result moved for %0d cycles", STALL_LIMIT);
    $display("matrix_chain_cost_evaluator_test: FAIL");
    $finish;
  end

  initial begin : run
    int               rand_from;
    int               i;
    int               n;
    int               base;
    int               pos;
    int               len;
    logic [SYM_W-1:0] c;
    logic [DIM_IN_W-1:0] dims [13];
    rst_ni = 1'b0;

    foreach (DIRECTED[k]) char_stream.push_back(DIRECTED[k]);

    // Fill the stack exactly, fold it back down, then overflow it
    queue_req(MODE_DEFINE, CH_C, DIM_1, DIM_1, MORE);
    for (i = 0; i < CHAIN_DEPTH; i++) queue_req(MODE_EXPR, CH_C, DIM_0, DIM_0, MORE);
    for (i = 1; i < CHAIN_DEPTH; i++)
      queue_req(MODE_EXPR, ASCII_RPAREN, DIM_0, DIM_0, i == CHAIN_DEPTH - 1);
    for (i = 0; i <= CHAIN_DEPTH; i++)
      queue_req(MODE_EXPR, CH_C, DIM_MAX, DIM_MAX, i == CHAIN_DEPTH);

    rand_from = char_stream.size();
    while (char_stream.size() < rand_from + RANDOM_CHARS) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          // garbled expression of letters, ')' and noise
          len = $urandom_range(1, 8);
          for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
              0: c = ASCII_A + 8'($urandom_range(0, TABLE_SIZE - 1));
              1: c = ASCII_RPAREN;
              default: c = noise_char();
            endcase
            queue_req(MODE_EXPR, c, 16'($urandom), 16'($urandom), i == len - 1);
          end
        end
        2: queue_req(MODE_DEFINE, 8'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom));
        default: begin
          // conforming chain: define its letters, then a random bracketing
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
          base = $urandom_range(0, TABLE_SIZE - 1);
          for (i = 0; i <= n; i++) begin
            case ($urandom_range(0, 9))
              0: dims[i] = 16'($urandom);
              1: dims[i] = DIM_MAX;
              default: dims[i] = 16'($urandom_range(0, 12));
            endcase
          end
          if ($urandom_range(0, 3) == 0)
            queue_req(MODE_DEFINE, 8'($urandom), 16'($urandom), 16'($urandom), MORE);
          for (i = 0; i < n; i++)
            queue_req(MODE_DEFINE, ASCII_A + 8'((base + i) % TABLE_SIZE), dims[i],
                      dims[i+1], $urandom_range(0, 7) == 0);
          scratch_chars.delete();
          build_tree(0, n - 1, base);
          // break one in five: drop, add ')', swap a letter, or end early
          if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, scratch_chars.size() - 1);
            case ($urandom_range(0, 3))
              0: scratch_chars.delete(pos);
              1: scratch_chars.insert(pos, ASCII_RPAREN);
              2: scratch_chars[pos] = ASCII_A + 8'($urandom_range(0, TABLE_SIZE - 1));
              default: while (scratch_chars.size() > pos + 1) void'(scratch_chars.pop_back());
            endcase
          end
          if (scratch_chars.size() == 0) scratch_chars.push_back(noise_char());
          foreach (scratch_chars[k]) begin
            if ($urandom_range(0, 9) == 0)
              queue_req(MODE_EXPR, noise_char(), 16'($urandom), 16'($urandom), MORE);
            queue_req(MODE_EXPR, scratch_chars[k], 16'($urandom), 16'($urandom),
                      k == scratch_chars.size() - 1);
          end
        end
      endcase
    end

    // Final stretch without gaps: a chain of the largest terms, back to back
    calm_from = char_stream.size();
    queue_req(MODE_DEFINE, ASCII_Z, DIM_MAX, DIM_MAX, MORE);
    queue_req(MODE_EXPR, ASCII_Z, 16'($urandom), 16'($urandom), MORE);
    for (i = 0; i < CALM_TERMS; i++) begin
      queue_req(MODE_EXPR, ASCII_Z, 16'($urandom), 16'($urandom), MORE);
      queue_req(MODE_EXPR, ASCII_RPAREN, 16'($urandom), 16'($urandom),
                i == CALM_TERMS - 1);
    end
    n_total = char_stream.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (n_accepted < n_total || pending_costs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests (%0d directed), %0d results checked, %0d of them errors",
             n_total, NUM_DIRECTED, n_results, n_err_results);
    $display("full and overflowed stack, largest terms, long output stall; %0d mismatches",
             n_fail);
    if (n_fail == 0) begin
      $display("matrix_chain_cost_evaluator_test: PASS");
    end else begin
      $display("matrix_chain_cost_evaluator_test: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/mcce_pkg.sv
sv/mcce_dim_table.sv
sv/mcce_stack_ram.sv
sv/matrix_chain_cost_evaluator.sv
tb/matrix_chain_cost_evaluator_test.sv
